### rtl/psa_pkg.sv
// shared types and constants for the pixel saturation adjust block
`default_nettype none
package psa_pkg;

   localparam int PIX_W     = 8;
   localparam int NUM_CH    = 3;
   localparam int WEIGHT_W  = 16;
   localparam int LUMA_SHIFT = 16;
   localparam int LPROD_W   = PIX_W + WEIGHT_W;
   localparam int DIFF_W    = PIX_W + 1;
   localparam int SCALE_W   = 16;
   localparam int SPROD_W   = DIFF_W + SCALE_W;
   localparam int SUM_W     = SPROD_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

   // luma weights over 2^16, index 0 red, 1 green, 2 blue
   localparam logic [NUM_CH-1:0][WEIGHT_W-1:0] LUMA_W = {16'd7209, 16'd38666, 16'd19661};

   localparam logic signed [SCALE_W-1:0] SCALE_RESET = 16'sd256;

   typedef enum logic [0:0] {
      REG_SATURATION_SCALE = 1'b0,
      REG_UNUSED           = 1'b1
   } reg_index_type;

   typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_type;

endpackage
`default_nettype wire

### rtl/pixel_saturation_adjust.sv
// pixel saturation adjust: luma-weighted rgb saturation with a signed scale
//
// usage: one rgb pixel is a word on the req_ channel (valid/ready), the
// adjusted pixel comes back as one word on the rsp_ channel (valid/ready).
// each channel becomes (c - luma) * scale / 2^SCALE_FRAC_BITS + luma, floored
// and clamped to 0..255; luma = (19661r + 38666g + 7209b) >> 16.
// the scale register sits at csr_ address 0 (apb-style, no wait states) and
// may only be changed while no word is in flight.
// an accepted word moves through the register stages in order and leaves the
// output register once the receiver is ready.
// throughput: one word per cycle while not stalled; each of the four register
// stages (luma products, luma and differences, scale products, floor/add/clamp
// into the output register) moves when the stage after it is empty or moving.
// reset clears all stage valid bits and loads the scale with 256 (identity).
// when the receiver stalls, words pile up in empty stages behind the output
// register; req_ready drops only once every stage holds a word.
`default_nettype none
module pixel_saturation_adjust
   import psa_pkg::*;
#(
   parameter int SCALE_FRAC_BITS = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire logic [PIX_W-1:0]       req_red_in,
   input  wire logic [PIX_W-1:0]       req_green_in,
   input  wire logic [PIX_W-1:0]       req_blue_in,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      logic [PIX_W-1:0]       rsp_red_out,
   output      logic [PIX_W-1:0]       rsp_green_out,
   output      logic [PIX_W-1:0]       rsp_blue_out,
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [CSR_DATA_W-1:0]  csr_prdata,
   output      logic                   csr_pready
);

   // configuration register
   logic signed [SCALE_W-1:0] scale_ff, scale_in;
   reg_index_type             csr_index;
   logic                      csr_write;

   // stage valids
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic adv1, adv2, adv3, adv4;

   // stage 1: luma products
   pixel_type                           ch1_ff, ch1_in;
   logic [NUM_CH-1:0][LPROD_W-1:0]      lprod1_ff, lprod1_in;
   // stage 2: luma and differences
   logic [PIX_W-1:0]                    luma2_ff, luma2_in;
   logic signed [DIFF_W-1:0]            diff2_ff [NUM_CH];
   logic signed [DIFF_W-1:0]            diff2_in [NUM_CH];
   // stage 3: scale products
   logic [PIX_W-1:0]                    luma3_ff, luma3_in;
   logic signed [SPROD_W-1:0]           sprod3_ff [NUM_CH];
   logic signed [SPROD_W-1:0]           sprod3_in [NUM_CH];
   // stage 4: output register
   pixel_type                           out4_ff, out4_in;

   logic [LPROD_W:0]                    luma_sum;
   logic signed [SPROD_W-1:0]           floored [NUM_CH];
   logic signed [SUM_W-1:0]             adjusted [NUM_CH];

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      scale_in = scale_ff;
      if (csr_write && csr_index == REG_SATURATION_SCALE) begin
         scale_in = signed'(csr_pwdata[SCALE_W-1:0]);
      end
   end

   always_comb begin
      case (csr_index)
         REG_SATURATION_SCALE: csr_prdata = CSR_DATA_W'(scale_ff);
         default:              csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- flow control
   assign adv4      = !v4_ff || rsp_ready;
   assign adv3      = !v3_ff || adv4;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;

   assign v1_in = adv1 ? req_valid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;
   assign v4_in = adv4 ? v3_ff : v4_ff;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      ch1_in = {req_blue_in, req_green_in, req_red_in};
      for (int i = 0; i < NUM_CH; i++) begin
         lprod1_in[i] = LPROD_W'(ch1_in[i]) * LPROD_W'(LUMA_W[i]);
      end
   end

   always_comb begin
      luma_sum = (LPROD_W+1)'(lprod1_ff[0]) + (LPROD_W+1)'(lprod1_ff[1])
               + (LPROD_W+1)'(lprod1_ff[2]);
      luma2_in = luma_sum[LUMA_SHIFT +: PIX_W];
      for (int i = 0; i < NUM_CH; i++) begin
         diff2_in[i] = signed'({1'b0, ch1_ff[i]}) - signed'({1'b0, luma2_in});
      end
   end

   always_comb begin
      luma3_in = luma2_ff;
      for (int i = 0; i < NUM_CH; i++) begin
         sprod3_in[i] = SPROD_W'(diff2_ff[i]) * SPROD_W'(scale_ff);
      end
   end

   // arithmetic shift floors toward minus infinity, then clamp
   always_comb begin
      for (int i = 0; i < NUM_CH; i++) begin
         floored[i]  = sprod3_ff[i] >>> SCALE_FRAC_BITS;
         adjusted[i] = SUM_W'(floored[i]) + signed'(SUM_W'(luma3_ff));
         if (adjusted[i] < 0) begin
            out4_in[i] = '0;
         end else if (adjusted[i] > signed'(SUM_W'(PIX_MAX))) begin
            out4_in[i] = PIX_MAX;
         end else begin
            out4_in[i] = adjusted[i][PIX_W-1:0];
         end
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
      end else begin
         scale_ff <= scale_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         v4_ff    <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         ch1_ff    <= ch1_in;
         lprod1_ff <= lprod1_in;
      end
      if (adv2) begin
         luma2_ff <= luma2_in;
         diff2_ff <= diff2_in;
      end
      if (adv3) begin
         luma3_ff  <= luma3_in;
         sprod3_ff <= sprod3_in;
      end
      if (adv4) begin
         out4_ff <= out4_in;
      end
   end

   assign rsp_valid     = v4_ff;
   assign rsp_red_out   = out4_ff[0];
   assign rsp_green_out = out4_ff[1];
   assign rsp_blue_out  = out4_ff[2];

endmodule
`default_nettype wire

### rtl/psa_checker.sv
// port-level checker for the pixel saturation adjust block, with its bind
`default_nettype none
module psa_checker
   import psa_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [PIX_W-1:0]      rsp_red_out,
   input wire logic [PIX_W-1:0]      rsp_green_out,
   input wire logic [PIX_W-1:0]      rsp_blue_out,
   input wire logic                  csr_psel,
   input wire logic                  csr_penable,
   input wire logic                  csr_pwrite,
   input wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input wire logic [CSR_DATA_W-1:0] csr_pwdata,
   input wire logic [CSR_DATA_W-1:0] csr_prdata
);

   // a stalled word stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled word keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_red_out) && $stable(rsp_green_out)
                                  && $stable(rsp_blue_out))
      else $error("rsp payload changed while stalled");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // a scale write reads back sign-extended
   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_paddr == '0
      |=> csr_paddr != '0
          || (csr_prdata[15:0] == $past(csr_pwdata[15:0])
              && csr_prdata[31:16] == {16{csr_prdata[15]}}))
      else $error("scale register readback mismatch");

endmodule

bind pixel_saturation_adjust psa_checker u_psa_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_red_out   (rsp_red_out),
   .rsp_green_out (rsp_green_out),
   .rsp_blue_out  (rsp_blue_out),
   .csr_psel      (csr_psel),
   .csr_penable   (csr_penable),
   .csr_pwrite    (csr_pwrite),
   .csr_paddr     (csr_paddr),
   .csr_pwdata    (csr_pwdata),
   .csr_prdata    (csr_prdata)
);
`default_nettype wire
